// ===== hw/rtl/mpss_pkg.sv =====
// ============================================================================
// mpss_pkg
// Shared types and constants for the multi-policy stride scheduler.
// ============================================================================
package mpss_pkg;

    localparam logic [16:0] STRIDE_BASE = 17'd100000;
    localparam logic [19:0] PASS_LIMIT  = 20'd1000000;
    localparam logic [6:0]  FULL_SHARE  = 7'd100;
    localparam int          DIV_NUM_W   = 17;
    localparam int          DIV_DEN_W   = 8;

    localparam logic [2:0] POL_ARB    = 3'd0;
    localparam logic [2:0] POL_FIFO   = 3'd1;
    localparam logic [2:0] POL_LIFO   = 3'd2;
    localparam logic [2:0] POL_RR     = 3'd3;
    localparam logic [2:0] POL_STRIDE = 3'd4;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_END   = 2'd1;
    localparam logic [1:0] MODE_SCHED = 2'd2;
    localparam logic [1:0] MODE_RATE  = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] client_id;
        logic [6:0]  rate_percent;
    } t_in;

    typedef struct packed {
        logic        ok;
        logic [15:0] chosen_id;
    } t_out;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_LOAD, CMD_SCAN, CMD_START, CMD_RSETUP, CMD_RATE,
        CMD_END_P4, CMD_END_FIRST, CMD_NOSHARE, CMD_DIVN, CMD_DIVQ, CMD_DIVS,
        CMD_TAKE_N, CMD_TAKE_Q, CMD_TAKE_S, CMD_SZERO, CMD_PASS, CMD_SCHED_RB,
        CMD_SADD, CMD_SCHED, CMD_RING_INIT, CMD_RING_STEP, CMD_RING_HIT
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] policy;
        logic       free_f;
        logic       first_f;
        logic       last_f;
        logic       best_f;
        logic       need_rb;
        logic       rate_bad;
        logic       rn_zero;
        logic       den_zero;
        logic       rest_zero;
        logic       div_done;
        logic       scan_end;
        logic       ring_head_bad;
        logic       ring_hit;
        logic       ring_stop;
    } t_stat;

endpackage

// ===== hw/rtl/mpss_div.sv =====
// ============================================================================
// mpss_div
// Restoring divider, one quotient bit per cycle.
// ============================================================================
module mpss_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [mpss_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [mpss_pkg::DIV_DEN_W-1:0] i_den,
    output logic                           o_done,
    output logic [mpss_pkg::DIV_NUM_W-1:0] o_quo
);
    import mpss_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_run;
    logic                 r_done;
    logic [DIV_DEN_W:0]   rem_sh;
    logic                 fits;

    assign rem_sh = {r_rem, r_quo[DIV_NUM_W-1]};
    assign fits   = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_cnt == CNT_W'(DIV_NUM_W - 1))) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= i_num;
            r_cnt <= '0;
        end else if (r_run) begin
            r_rem <= fits ? DIV_DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], fits};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== hw/rtl/mpss_ctrl.sv =====
// ============================================================================
// mpss_ctrl
// Sequencer that steps the datapath through the work of one item.
// ============================================================================
module mpss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  mpss_pkg::t_stat  i_stat,
    output mpss_pkg::t_cmd   o_cmd,
    output logic             busy,
    output logic             o_done
);
    import mpss_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_DECIDE, ST_RATE, ST_DIVN, ST_WAITN, ST_DIVQ, ST_WAITQ,
        ST_DIVS, ST_WAITS, ST_PASS, ST_RBPASS, ST_SADD, ST_RING0, ST_RING, ST_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_done;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = CMD_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    cmd     = CMD_LOAD;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd = CMD_SCAN;
                if (i_stat.scan_end) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_state = ST_FIN;
                unique case (i_stat.mode)
                    MODE_START: begin
                        if (i_stat.free_f) begin
                            cmd = CMD_START;
                            if (i_stat.policy == POL_STRIDE) n_state = ST_RATE;
                        end
                    end
                    MODE_END: begin
                        if (i_stat.policy == POL_RR) begin
                            n_state = ST_RING0;
                        end else if (i_stat.policy == POL_STRIDE) begin
                            if (i_stat.last_f) begin
                                cmd     = CMD_END_P4;
                                n_state = ST_DIVQ;
                            end
                        end else if (i_stat.first_f) begin
                            cmd = CMD_END_FIRST;
                        end
                    end
                    MODE_SCHED: begin
                        if (i_stat.policy == POL_STRIDE) begin
                            if (i_stat.best_f) begin
                                if (i_stat.need_rb) begin
                                    cmd     = CMD_SCHED_RB;
                                    n_state = ST_RBPASS;
                                end else begin
                                    n_state = ST_SADD;
                                end
                            end
                        end else begin
                            cmd = CMD_SCHED;
                        end
                    end
                    default: begin
                        if (i_stat.last_f) begin
                            cmd     = CMD_RSETUP;
                            n_state = ST_RATE;
                        end
                    end
                endcase
            end
            ST_RATE: begin
                if (i_stat.rate_bad) begin
                    n_state = ST_FIN;
                end else begin
                    cmd     = CMD_RATE;
                    n_state = i_stat.rn_zero ? ST_DIVQ : ST_DIVN;
                end
            end
            ST_DIVN: begin
                cmd     = CMD_DIVN;
                n_state = ST_WAITN;
            end
            ST_WAITN: begin
                if (i_stat.div_done) begin
                    cmd     = CMD_TAKE_N;
                    n_state = ST_DIVQ;
                end
            end
            ST_DIVQ: begin
                if (i_stat.den_zero) begin
                    cmd     = CMD_NOSHARE;
                    n_state = ST_PASS;
                end else begin
                    cmd     = CMD_DIVQ;
                    n_state = ST_WAITQ;
                end
            end
            ST_WAITQ: begin
                if (i_stat.div_done) begin
                    cmd     = CMD_TAKE_Q;
                    n_state = ST_DIVS;
                end
            end
            ST_DIVS: begin
                if (i_stat.rest_zero) begin
                    cmd     = CMD_SZERO;
                    n_state = ST_PASS;
                end else begin
                    cmd     = CMD_DIVS;
                    n_state = ST_WAITS;
                end
            end
            ST_WAITS: begin
                if (i_stat.div_done) begin
                    cmd     = CMD_TAKE_S;
                    n_state = ST_PASS;
                end
            end
            ST_PASS: begin
                cmd = CMD_PASS;
                if (i_stat.scan_end) n_state = ST_FIN;
            end
            ST_RBPASS: begin
                cmd = CMD_PASS;
                if (i_stat.scan_end) n_state = ST_SADD;
            end
            ST_SADD: begin
                cmd     = CMD_SADD;
                n_state = ST_FIN;
            end
            ST_RING0: begin
                if (i_stat.ring_head_bad) begin
                    n_state = ST_FIN;
                end else begin
                    cmd     = CMD_RING_INIT;
                    n_state = ST_RING;
                end
            end
            ST_RING: begin
                if (i_stat.ring_hit) begin
                    cmd     = CMD_RING_HIT;
                    n_state = ST_FIN;
                end else if (i_stat.ring_stop) begin
                    n_state = ST_FIN;
                end else begin
                    cmd = CMD_RING_STEP;
                end
            end
            ST_FIN: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (n_state == ST_FIN);
        end
    end

    assign o_cmd  = cmd;
    assign busy   = (r_state != ST_IDLE);
    assign o_done = r_done;

endmodule

// ===== hw/rtl/mpss_dp.sv =====
// ============================================================================
// mpss_dp
// Client table, policy structures, scan accumulators and the shared divider.
// ============================================================================
module mpss_dp #(
    parameter int NUM_SLOTS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_data,
    input  mpss_pkg::t_in   i_item,
    input  mpss_pkg::t_cmd  i_cmd,
    output mpss_pkg::t_stat o_stat,
    output mpss_pkg::t_out  o_result
);
    import mpss_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LW = $clog2(NUM_SLOTS + 1);
    localparam logic [LW-1:0] LNULL = LW'(NUM_SLOTS);
    localparam logic [IW-1:0] ILAST = IW'(NUM_SLOTS - 1);

    // Table and policy structures.
    logic          r_valid  [NUM_SLOTS];
    logic [15:0]   r_id     [NUM_SLOTS];
    logic [LW-1:0] r_link   [NUM_SLOTS];
    logic [6:0]    r_req    [NUM_SLOTS];
    logic [16:0]   r_stride [NUM_SLOTS];
    logic [19:0]   r_pass   [NUM_SLOTS];
    logic [IW-1:0] r_fifo   [NUM_SLOTS];
    logic [IW-1:0] r_stack  [NUM_SLOTS];
    logic [6:0]    r_unclaimed;
    logic [LW-1:0] r_head, r_tail, r_cursor;
    logic [IW-1:0] r_rd, r_wr;
    logic [LW-1:0] r_fcnt, r_depth;
    logic [2:0]    r_policy;

    // Item and per-item working registers.
    logic [1:0]    r_mode;
    logic [15:0]   r_cid;
    logic [6:0]    r_n;
    logic [IW-1:0] r_k;
    logic [IW-1:0] r_free, r_first, r_last, r_fv, r_best;
    logic          r_free_f, r_first_f, r_last_f, r_fv_f, r_best_f, r_any;
    logic [19:0]   r_minv, r_bestp, r_minp;
    logic [LW-1:0] r_cnt, r_den;
    logic [IW-1:0] r_t;
    logic [6:0]    r_rn;
    logic [7:0]    r_num, r_rest;
    logic [16:0]   r_s;
    logic          r_share, r_rebase;
    logic [LW-1:0] r_wi, r_wpre;
    logic [IW-1:0] r_step;
    logic          r_ok;
    logic [15:0]   r_chosen;

    // Combinational helpers.
    logic [7:0]    total, rest_num, end_sum;
    logic [6:0]    end_unc;
    logic [LW-1:0] noreq, end_den;
    logic          rate_bad;
    logic [19:0]   min_lim;
    logic [20:0]   sched_sum;
    logic          slot_match;
    logic [IW-1:0] wi_idx, head_idx, tail_idx, pre_idx;
    logic [LW-1:0] wi_link;
    logic [IW-1:0] fifo_nxt_wr, fifo_nxt_rd;
    logic [LW-1:0] cur_sel;
    logic          cur_bad, sel_bad;
    logic [IW-1:0] stack_top, lifo_slot, fifo_slot;
    logic          div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num, div_quo;
    logic [DIV_DEN_W-1:0] div_den;

    assign total     = {1'b0, r_req[r_t]} + {1'b0, r_unclaimed};
    assign rest_num  = total - {1'b0, r_rn};
    assign rate_bad  = (r_rn > FULL_SHARE) || ({1'b0, r_rn} > total);
    assign noreq     = r_cnt - LW'(r_req[r_t] == 7'd0) + LW'(r_rn == 7'd0);
    assign end_sum   = {1'b0, r_unclaimed} + {1'b0, r_req[r_last]};
    assign end_unc   = (end_sum > {1'b0, FULL_SHARE}) ? FULL_SHARE : end_sum[6:0];
    assign end_den   = r_cnt - LW'(r_req[r_last] == 7'd0);
    assign min_lim   = (r_minv > PASS_LIMIT) ? PASS_LIMIT : r_minv;
    assign sched_sum = {1'b0, r_bestp} + {4'b0, r_stride[r_best]};
    assign slot_match = r_valid[r_k] && (r_id[r_k] == r_cid);

    assign wi_idx   = r_wi[IW-1:0];
    assign head_idx = r_head[IW-1:0];
    assign tail_idx = r_tail[IW-1:0];
    assign pre_idx  = r_wpre[IW-1:0];
    assign wi_link  = r_link[wi_idx];

    assign fifo_nxt_wr = (r_wr == ILAST) ? '0 : r_wr + 1'b1;
    assign fifo_nxt_rd = (r_rd == ILAST) ? '0 : r_rd + 1'b1;
    assign fifo_slot   = r_fifo[r_rd];
    assign stack_top   = IW'(r_depth - 1'b1);
    assign lifo_slot   = r_stack[stack_top];

    // Round-robin cursor falls back to the head when it is null or unlinked.
    assign cur_bad = (r_cursor >= LNULL) || (r_link[r_cursor[IW-1:0]] == LNULL);
    assign cur_sel = cur_bad ? r_head : r_cursor;
    assign sel_bad = (cur_sel >= LNULL) || (r_link[cur_sel[IW-1:0]] == LNULL);

    assign div_start = (i_cmd == CMD_DIVN) || (i_cmd == CMD_DIVQ) || (i_cmd == CMD_DIVS);
    assign div_num   = (i_cmd == CMD_DIVQ) ? DIV_NUM_W'(r_num) : STRIDE_BASE;
    always_comb begin
        case (i_cmd)
            CMD_DIVN: div_den = DIV_DEN_W'(r_rn);
            CMD_DIVQ: div_den = DIV_DEN_W'(r_den);
            default:  div_den = r_rest;
        endcase
    end

    mpss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Table state with defined reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_valid[i]  <= 1'b0;
                r_link[i]   <= LNULL;
                r_req[i]    <= '0;
                r_stride[i] <= '0;
                r_pass[i]   <= '0;
            end
            r_unclaimed <= FULL_SHARE;
            r_head      <= '0;
            r_tail      <= '0;
            r_cursor    <= '0;
            r_rd        <= '0;
            r_wr        <= '0;
            r_fcnt      <= '0;
            r_depth     <= '0;
            r_policy    <= POL_STRIDE;
        end else begin
            if (i_cfg_we) r_policy <= i_cfg_data;
            case (i_cmd)
                CMD_START: begin
                    r_valid[r_free] <= 1'b1;
                    if (r_policy == POL_FIFO) begin
                        if (r_fcnt < LNULL) begin
                            r_wr   <= fifo_nxt_wr;
                            r_fcnt <= r_fcnt + 1'b1;
                        end
                    end else if (r_policy == POL_LIFO) begin
                        if (r_depth < LNULL) r_depth <= r_depth + 1'b1;
                    end else if (r_policy == POL_RR) begin
                        if ((r_head >= LNULL) || (r_tail >= LNULL)
                            || (r_link[head_idx] == LNULL)) begin
                            r_head         <= LW'(r_free);
                            r_tail         <= LW'(r_free);
                            r_link[r_free] <= LW'(r_free);
                        end else begin
                            r_link[tail_idx] <= LW'(r_free);
                            r_link[r_free]   <= r_head;
                            r_tail           <= LW'(r_free);
                        end
                    end else if (r_policy == POL_STRIDE) begin
                        r_pass[r_free] <= r_any ? r_minv : '0;
                    end
                end
                CMD_RATE: begin
                    r_unclaimed <= (rest_num > {1'b0, FULL_SHARE}) ? FULL_SHARE : rest_num[6:0];
                    r_req[r_t]  <= r_rn;
                    if (r_rn == 7'd0) r_stride[r_t] <= '0;
                end
                CMD_TAKE_N: r_stride[r_t] <= div_quo;
                CMD_END_P4: begin
                    r_valid[r_last] <= 1'b0;
                    r_unclaimed     <= end_unc;
                    r_req[r_last]   <= '0;
                end
                CMD_END_FIRST: begin
                    r_valid[r_first] <= 1'b0;
                    r_unclaimed      <= (({1'b0, r_unclaimed} + {1'b0, r_req[r_first]})
                                        > {1'b0, FULL_SHARE}) ? FULL_SHARE
                                        : r_unclaimed + r_req[r_first];
                    r_req[r_first]   <= '0;
                    if (r_depth != '0) r_depth <= r_depth - 1'b1;
                    if (r_fcnt != '0) begin
                        r_rd   <= fifo_nxt_rd;
                        r_fcnt <= r_fcnt - 1'b1;
                    end
                end
                CMD_PASS: begin
                    if (r_share && (r_req[r_k] == 7'd0)) r_stride[r_k] <= r_s;
                    if (r_rebase && r_valid[r_k]) r_pass[r_k] <= r_pass[r_k] - r_minp;
                end
                CMD_SADD: r_pass[r_best] <= r_pass[r_best] + {3'b0, r_stride[r_best]};
                CMD_SCHED: begin
                    if ((r_policy == POL_RR) && !sel_bad) begin
                        r_cursor <= r_link[cur_sel[IW-1:0]];
                    end
                end
                CMD_RING_HIT: begin
                    r_valid[wi_idx] <= 1'b0;
                    r_unclaimed     <= (({1'b0, r_unclaimed} + {1'b0, r_req[wi_idx]})
                                       > {1'b0, FULL_SHARE}) ? FULL_SHARE
                                       : r_unclaimed + r_req[wi_idx];
                    r_req[wi_idx]   <= '0;
                    if (wi_link == r_wi) begin
                        r_link[wi_idx] <= LNULL;
                    end else if (r_wi == r_head) begin
                        r_head <= wi_link;
                        if (r_tail < LNULL) r_link[tail_idx] <= wi_link;
                        r_link[wi_idx] <= LNULL;
                    end else if (r_wpre < LNULL) begin
                        r_link[pre_idx] <= wi_link;
                        if (r_wi == r_tail) r_tail <= r_wpre;
                        r_link[wi_idx] <= LNULL;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload stores and per-item working registers.
    always_ff @(posedge i_clk) begin
        r_k <= ((i_cmd == CMD_SCAN) || (i_cmd == CMD_PASS))
               ? ((r_k == ILAST) ? '0 : r_k + 1'b1) : '0;
        case (i_cmd)
            CMD_LOAD: begin
                r_mode    <= i_item.mode;
                r_cid     <= i_item.client_id;
                r_n       <= i_item.rate_percent;
                r_free_f  <= 1'b0;
                r_first_f <= 1'b0;
                r_last_f  <= 1'b0;
                r_fv_f    <= 1'b0;
                r_best_f  <= 1'b0;
                r_any     <= 1'b0;
                r_minv    <= '0;
                r_cnt     <= '0;
                r_ok      <= 1'b0;
                r_chosen  <= '0;
            end
            CMD_SCAN: begin
                if (!r_valid[r_k] && !r_free_f) begin
                    r_free   <= r_k;
                    r_free_f <= 1'b1;
                end
                if (slot_match && !r_first_f) begin
                    r_first   <= r_k;
                    r_first_f <= 1'b1;
                end
                if (slot_match) begin
                    r_last   <= r_k;
                    r_last_f <= 1'b1;
                end
                if (r_valid[r_k]) begin
                    if (!r_fv_f) begin
                        r_fv   <= r_k;
                        r_fv_f <= 1'b1;
                    end
                    if (!r_any || (r_pass[r_k] < r_minv)) r_minv <= r_pass[r_k];
                    r_any <= 1'b1;
                    if (r_req[r_k] == 7'd0) r_cnt <= r_cnt + 1'b1;
                    if (!((r_req[r_k] == 7'd0) && (r_unclaimed == 7'd0))
                        && (!r_best_f || (r_pass[r_k] <= r_bestp))) begin
                        r_best   <= r_k;
                        r_bestp  <= r_pass[r_k];
                        r_best_f <= 1'b1;
                    end
                end
            end
            CMD_START: begin
                r_id[r_free] <= r_cid;
                r_ok         <= 1'b1;
                if ((r_policy == POL_FIFO) && (r_fcnt < LNULL)) r_fifo[r_wr] <= r_free;
                if ((r_policy == POL_LIFO) && (r_depth < LNULL)) begin
                    r_stack[r_depth[IW-1:0]] <= r_free;
                end
                // The new entry joins the unrequested count of the rate update.
                r_t    <= r_free;
                r_rn   <= '0;
                r_minp <= r_any ? min_lim : '0;
                r_cnt  <= r_cnt + 1'b1;
            end
            CMD_RSETUP: begin
                r_t    <= r_last;
                r_rn   <= r_n;
                r_minp <= min_lim;
            end
            CMD_RATE: begin
                r_num    <= rest_num;
                r_den    <= noreq;
                r_share  <= 1'b1;
                r_rebase <= 1'b1;
                r_ok     <= 1'b1;
            end
            CMD_END_P4: begin
                r_num    <= {1'b0, end_unc};
                r_den    <= end_den;
                r_share  <= 1'b1;
                r_rebase <= 1'b0;
                r_ok     <= 1'b1;
            end
            CMD_END_FIRST: r_ok <= 1'b1;
            CMD_NOSHARE:   r_share <= 1'b0;
            CMD_TAKE_Q:    r_rest <= div_quo[7:0];
            CMD_TAKE_S:    r_s <= div_quo;
            CMD_SZERO:     r_s <= '0;
            CMD_SCHED_RB: begin
                r_minp   <= r_bestp;
                r_share  <= 1'b0;
                r_rebase <= 1'b1;
            end
            CMD_SADD: begin
                r_ok     <= 1'b1;
                r_chosen <= r_id[r_best];
            end
            CMD_SCHED: begin
                case (r_policy)
                    POL_ARB: begin
                        if (r_fv_f) begin
                            r_ok     <= 1'b1;
                            r_chosen <= r_id[r_fv];
                        end
                    end
                    POL_FIFO: begin
                        if ((r_fcnt != '0) && r_valid[fifo_slot]) begin
                            r_ok     <= 1'b1;
                            r_chosen <= r_id[fifo_slot];
                        end
                    end
                    POL_LIFO: begin
                        if ((r_depth != '0) && r_valid[lifo_slot]) begin
                            r_ok     <= 1'b1;
                            r_chosen <= r_id[lifo_slot];
                        end
                    end
                    POL_RR: begin
                        if (!sel_bad && r_valid[cur_sel[IW-1:0]]) begin
                            r_ok     <= 1'b1;
                            r_chosen <= r_id[cur_sel[IW-1:0]];
                        end
                    end
                    default: ;
                endcase
            end
            CMD_RING_INIT: begin
                r_wi   <= r_head;
                r_wpre <= LNULL;
                r_step <= '0;
            end
            CMD_RING_STEP: begin
                r_wpre <= r_wi;
                r_wi   <= wi_link;
                r_step <= r_step + 1'b1;
            end
            CMD_RING_HIT: r_ok <= 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        o_stat.mode          = r_mode;
        o_stat.policy        = r_policy;
        o_stat.free_f        = r_free_f;
        o_stat.first_f       = r_first_f;
        o_stat.last_f        = r_last_f;
        o_stat.best_f        = r_best_f;
        o_stat.need_rb       = (sched_sum > {1'b0, PASS_LIMIT});
        o_stat.rate_bad      = rate_bad;
        o_stat.rn_zero       = (r_rn == 7'd0);
        o_stat.den_zero      = (r_den == '0);
        o_stat.rest_zero     = (r_rest == 8'd0);
        o_stat.div_done      = div_done;
        o_stat.scan_end      = (r_k == ILAST);
        o_stat.ring_head_bad = (r_head >= LNULL) || (r_link[head_idx] == LNULL);
        o_stat.ring_hit      = r_valid[wi_idx] && (r_id[wi_idx] == r_cid);
        o_stat.ring_stop     = (wi_link >= LNULL) || (wi_link == r_head) || (r_step == ILAST);
    end

    assign o_result.ok        = r_ok;
    assign o_result.chosen_id = r_chosen;

endmodule

// ===== hw/rtl/multi_policy_stride_scheduler_top.sv =====
// ============================================================================
// multi_policy_stride_scheduler_top
// Client-slot scheduler with arbitrary, FIFO, LIFO, round-robin and stride
// policies.
// ============================================================================
// An item is taken when start is high and busy is low; its one result shows
// on o_result for the single cycle that o_done is high and cannot be held
// off. Every item first scans the table one slot per cycle, then passes
// through a decide state and ends in a finish state. Start, end and
// schedule under the simple policies go from the decide state straight to
// the finish state. A stride schedule that must rebase adds another slot
// sweep. Accepted rate requests, stride starts and stride ends run up to
// three passes of the shared divider followed by a slot sweep. A
// round-robin end walks the ring one link per cycle. The policy register
// is written through i_cfg_we; the user must write it only while the block
// is idle, and the block itself does not enforce this.
module multi_policy_stride_scheduler_top #(
    parameter int NUM_SLOTS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_data,
    input  logic           start,
    input  mpss_pkg::t_in  i_item,
    output logic           busy,
    output logic           o_done,
    output mpss_pkg::t_out o_result
);
    import mpss_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    mpss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    mpss_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_result   (o_result)
    );

endmodule

// ===== hw/rtl/mpss_chk.sv =====
// ============================================================================
// mpss_chk
// Port-level checks of the scheduler's command handshake and results.
// ============================================================================
module mpss_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_done,
    input mpss_pkg::t_out o_result
);
    import mpss_pkg::*;

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but busy did not rise");

    a_single_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");

    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe outside an item");

    a_fail_no_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.ok) |-> (o_result.chosen_id == 16'd0))
        else $error("failed item reported a client id");

endmodule

bind multi_policy_stride_scheduler_top mpss_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

// ===== test/mpss_checker.sv =====
// ----------------------------------------------------------------------------
// mpss_checker
// Watches the item and result channels of the stride scheduler, keeps its own
// copy of the slot table, and checks every result against the prediction.
// ----------------------------------------------------------------------------
module mpss_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  logic [2:0] i_cfg_data,
    input  logic  start,
    input  logic  busy,
    input  mpss_pkg::t_in   i_item,
    input  logic  o_done,
    input  mpss_pkg::t_out  o_result,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import mpss_pkg::*;

    localparam int          SLOTS     = 16;
    localparam logic [4:0]  LINK_NULL = 5'd16;

    logic [2:0]   policy;
    logic         valid_q   [SLOTS];
    logic [15:0]  id_q      [SLOTS];
    logic [4:0]   link_q    [SLOTS];
    int unsigned  request_q [SLOTS];
    logic [16:0]  stride_q  [SLOTS];
    int unsigned  pass_q    [SLOTS];
    int unsigned  unclaimed;
    logic [4:0]   ring_head, ring_tail, ring_cursor;
    logic [3:0]   fifo_slot [SLOTS];
    logic [3:0]   fifo_rd, fifo_wr;
    int unsigned  fifo_cnt;
    logic [3:0]   stack_slot [SLOTS];
    int unsigned  stack_cnt;

    t_out expected_results[$];
    int   fail_count = 0;
    int   checked = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();
    assign o_checked    = checked;

    function automatic void clear_table();
        policy = POL_STRIDE;
        for (int i = 0; i < SLOTS; i++) begin
            valid_q[i] = 1'b0; id_q[i] = '0; link_q[i] = LINK_NULL;
            request_q[i] = 0; stride_q[i] = '0; pass_q[i] = 0;
            fifo_slot[i] = '0; stack_slot[i] = '0;
        end
        unclaimed = 100;
        ring_head = '0; ring_tail = '0; ring_cursor = '0;
        fifo_rd = '0; fifo_wr = '0; fifo_cnt = 0; stack_cnt = 0;
    endfunction

    function automatic int last_slot_of(logic [15:0] id);
        int t = -1;
        for (int i = 0; i < SLOTS; i++)
            if (valid_q[i] && id_q[i] == id) t = i;
        return t;
    endfunction

    // Every entry without a request gets the same stride, valid or not.
    function automatic void share_pool(int unsigned rest);
        logic [16:0] s = rest != 0 ? 17'(100000 / rest) : '0;
        for (int i = 0; i < SLOTS; i++)
            if (request_q[i] == 0) stride_q[i] = s;
    endfunction

    function automatic void lower_passes(int unsigned m);
        for (int i = 0; i < SLOTS; i++)
            if (valid_q[i]) pass_q[i] = pass_q[i] - m;
    endfunction

    function automatic void release_slot(int i);
        int unsigned u = unclaimed + request_q[i];
        valid_q[i] = 1'b0;
        unclaimed = u > 100 ? 100 : u;
        request_q[i] = 0;
    endfunction

    function automatic bit grant_rate(int t, int unsigned n);
        int unsigned noreq = 0;
        int unsigned minp = 1000000;
        int unsigned total;
        if (n > 100) return 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (valid_q[i]) begin
                if (pass_q[i] < minp) minp = pass_q[i];
                if (i != t && request_q[i] == 0) noreq++;
            end
        end
        total = request_q[t] + unclaimed;
        if (n > total) return 1'b0;
        unclaimed = (total - n) > 100 ? 100 : total - n;
        request_q[t] = n;
        stride_q[t] = n != 0 ? 17'(100000 / n) : '0;
        if (n == 0) noreq++;
        if (noreq != 0) share_pool((total - n) / noreq);
        lower_passes(minp);
        return 1'b1;
    endfunction

    function automatic bit start_client(logic [15:0] id);
        int i = -1;
        bit any = 1'b0;
        int unsigned minp = 0;
        bit unused;
        for (int k = 0; k < SLOTS; k++)
            if (!valid_q[k] && i < 0) i = k;
        if (i < 0) return 1'b0;
        for (int k = 0; k < SLOTS; k++)
            if (valid_q[k] && (!any || pass_q[k] < minp)) begin
                minp = pass_q[k]; any = 1'b1;
            end
        valid_q[i] = 1'b1;
        id_q[i] = id;
        case (policy)
            POL_FIFO: begin
                if (fifo_cnt < SLOTS) begin
                    fifo_slot[fifo_wr] = 4'(i);
                    fifo_wr = fifo_wr + 4'd1;
                    fifo_cnt++;
                end
            end
            POL_LIFO: begin
                if (stack_cnt < SLOTS) begin
                    stack_slot[stack_cnt] = 4'(i);
                    stack_cnt++;
                end
            end
            POL_RR: begin
                if (ring_head >= LINK_NULL || ring_tail >= LINK_NULL
                        || link_q[ring_head] == LINK_NULL) begin
                    ring_head = 5'(i); ring_tail = 5'(i);
                    link_q[i] = 5'(i);
                end else begin
                    link_q[ring_tail] = 5'(i);
                    link_q[i] = ring_head;
                    ring_tail = 5'(i);
                end
            end
            POL_STRIDE: begin
                pass_q[i] = minp;
                unused = grant_rate(i, 0);
            end
            default: ;
        endcase
        return 1'b1;
    endfunction

    function automatic bit end_in_ring(logic [15:0] id);
        logic [4:0] i = ring_head;
        logic [4:0] pre = LINK_NULL;
        if (i >= LINK_NULL || link_q[i] == LINK_NULL) return 1'b0;
        for (int k = 0; k < SLOTS; k++) begin
            if (valid_q[i] && id_q[i] == id) begin
                release_slot(i);
                if (link_q[i] == i) begin
                    link_q[i] = LINK_NULL;
                end else if (i == ring_head) begin
                    ring_head = link_q[i];
                    if (ring_tail < LINK_NULL) link_q[ring_tail] = ring_head;
                    link_q[i] = LINK_NULL;
                end else if (pre < LINK_NULL) begin
                    link_q[pre] = link_q[i];
                    if (i == ring_tail) ring_tail = pre;
                    link_q[i] = LINK_NULL;
                end
                return 1'b1;
            end
            pre = i;
            i = link_q[i];
            if (i >= LINK_NULL || i == ring_head) break;
        end
        return 1'b0;
    endfunction

    function automatic bit end_client(logic [15:0] id);
        int t;
        int unsigned cnt = 0;
        if (policy == POL_RR) return end_in_ring(id);
        if (policy == POL_STRIDE) begin
            t = last_slot_of(id);
            if (t < 0) return 1'b0;
            release_slot(t);
            for (int i = 0; i < SLOTS; i++)
                if (valid_q[i] && request_q[i] == 0) cnt++;
            if (cnt != 0) share_pool(unclaimed / cnt);
            return 1'b1;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (valid_q[i] && id_q[i] == id) begin
                release_slot(i);
                if (stack_cnt > 0) stack_cnt--;
                if (fifo_cnt > 0) begin
                    fifo_rd = fifo_rd + 4'd1;
                    fifo_cnt--;
                end
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit pick_client(output logic [15:0] chosen);
        logic [4:0] i;
        int best = -1;
        int unsigned minp = 0;
        chosen = '0;
        case (policy)
            POL_ARB: begin
                for (int k = 0; k < SLOTS; k++)
                    if (valid_q[k]) begin
                        chosen = id_q[k];
                        return 1'b1;
                    end
                return 1'b0;
            end
            POL_FIFO, POL_LIFO: begin
                if (policy == POL_FIFO) begin
                    if (fifo_cnt == 0) return 1'b0;
                    i = {1'b0, fifo_slot[fifo_rd]};
                end else begin
                    if (stack_cnt == 0 || stack_cnt > SLOTS) return 1'b0;
                    i = {1'b0, stack_slot[stack_cnt - 1]};
                end
                if (valid_q[i]) begin
                    chosen = id_q[i];
                    return 1'b1;
                end
                return 1'b0;
            end
            POL_RR: begin
                i = ring_cursor;
                if (i >= LINK_NULL || link_q[i] == LINK_NULL) i = ring_head;
                if (i >= LINK_NULL || link_q[i] == LINK_NULL) return 1'b0;
                ring_cursor = link_q[i];
                if (valid_q[i]) begin
                    chosen = id_q[i];
                    return 1'b1;
                end
                return 1'b0;
            end
            POL_STRIDE: begin
                for (int k = 0; k < SLOTS; k++) begin
                    if (!valid_q[k]) continue;
                    if (request_q[k] == 0 && unclaimed == 0) continue;
                    if (best < 0 || pass_q[k] <= minp) begin
                        minp = pass_q[k]; best = k;
                    end
                end
                if (best < 0) return 1'b0;
                if (minp + stride_q[best] > 1000000) lower_passes(minp);
                pass_q[best] = (pass_q[best] + stride_q[best]) & 32'hFFFFF;
                chosen = id_q[best];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_out predict_item(t_in it);
        t_out r;
        logic [15:0] pick;
        int t;
        r = '0;
        case (it.mode)
            MODE_START: r.ok = start_client(it.client_id);
            MODE_END:   r.ok = end_client(it.client_id);
            MODE_SCHED: begin
                r.ok = pick_client(pick);
                r.chosen_id = r.ok ? pick : 16'd0;
            end
            default: begin
                t = last_slot_of(it.client_id);
                r.ok = (t >= 0) && grant_rate(t, it.rate_percent);
            end
        endcase
        return r;
    endfunction

    task automatic report(string what, int unsigned want, int unsigned got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            clear_table();
            expected_results.delete();
        end else begin
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    report("unexpected result", 0, 1);
                end else begin
                    want = expected_results.pop_front();
                    checked++;
                    if (o_result.ok !== want.ok)
                        report("ok", want.ok, o_result.ok);
                    if (o_result.chosen_id !== want.chosen_id)
                        report("chosen_id", want.chosen_id, o_result.chosen_id);
                end
            end
            if (i_cfg_we) policy = i_cfg_data;
            if (start && !busy) expected_results.push_back(predict_item(i_item));
        end
    end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random client requests into the stride scheduler under
// policy settings 0 to 5 and 7, with random gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mpss_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 150;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_data = POL_STRIDE;
    logic start = 1'b0;
    t_in  i_item = '0;
    logic busy, o_done;
    t_out o_result;
    int fail_count, pending, checked;
    int cycles = 0;
    int items_sent = 0;

    logic [15:0] id_pool [8] = '{16'd0, 16'd1, 16'd2, 16'd3,
                                 16'h5555, 16'hAAAA, 16'hFFFF, 16'h8001};
    logic [2:0]  policies [10] = '{POL_ARB, POL_FIFO, POL_LIFO, POL_RR, POL_STRIDE,
                                   3'd5, 3'd7, POL_RR, POL_FIFO, POL_STRIDE};

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    multi_policy_stride_scheduler_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data), .start(start), .i_item(i_item),
        .busy(busy), .o_done(o_done), .o_result(o_result)
    );

    mpss_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data), .start(start), .busy(busy), .i_item(i_item),
        .o_done(o_done), .o_result(o_result), .o_fail_count(fail_count),
        .o_pending(pending), .o_checked(checked)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** multi_policy_stride_scheduler_top: FAILED **");
            $finish;
        end
    end

    // Holds the item until the block takes it, then leaves start high when
    // the next item follows without a gap.
    task automatic send_item(logic [1:0] mode, logic [15:0] id, logic [6:0] pct, int gap);
        start  <= 1'b1;
        i_item <= '{mode: mode, client_id: id, rate_percent: pct};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        if (start) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_policy(logic [2:0] pol);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= pol;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int pick_gap();
        int r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(15, 80);
    endfunction

    task automatic random_item(bit quiet);
        int r = $urandom_range(0, 99);
        logic [1:0] mode;
        logic [15:0] id;
        logic [6:0] pct;
        mode = r < 30 ? MODE_START : r < 50 ? MODE_END : r < 85 ? MODE_SCHED : MODE_RATE;
        id   = $urandom_range(0, 19) == 0 ? 16'($urandom) : id_pool[$urandom_range(0, 7)];
        pct  = $urandom_range(0, 9) == 0 ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(0, 100));
        send_item(mode, id, pct, quiet ? 0 : pick_gap());
    endtask

    initial begin
        int per_phase;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Stride policy out of reset: extremes of ids and rates, a full table.
        send_item(MODE_START, 16'd0, 7'd0, 0);
        send_item(MODE_START, 16'hFFFF, 7'd0, 1);
        send_item(MODE_RATE, 16'd0, 7'd100, 0);
        send_item(MODE_RATE, 16'hFFFF, 7'd0, 2);
        send_item(MODE_RATE, 16'd0, 7'd127, 0);
        send_item(MODE_RATE, 16'h1234, 7'd50, 0);
        send_item(MODE_SCHED, 16'd0, 7'd0, 0);
        send_item(MODE_SCHED, 16'd0, 7'd0, 0);
        send_item(MODE_END, 16'h1234, 7'd0, 0);
        for (int k = 0; k < 15; k++) send_item(MODE_START, 16'd7, 7'd0, 0);
        send_item(MODE_END, 16'd7, 7'd0, 0);
        send_item(MODE_SCHED, 16'd0, 7'd0, 0);

        per_phase = RANDOM_ITEMS / 10;
        for (int p = 0; p < 10; p++) begin
            set_policy(policies[p]);
            for (int k = 0; k < per_phase; k++) begin
                if (k == per_phase / 2 && p % 3 == 0) begin
                    // Let the checker see the last item before waiting on it.
                    start <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0) @(posedge i_clk);
                end
                random_item(p == 4);
            end
        end
        drain();

        $display("sent %0d items, checked %0d results", items_sent, checked);
        $display("covered policies 0-5 and 7 with directed and random requests");
        if (fail_count == 0) begin
            $display("** multi_policy_stride_scheduler_top: PASSED **");
        end else begin
            $display("** multi_policy_stride_scheduler_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/mpss_pkg.sv
hw/rtl/mpss_div.sv
hw/rtl/mpss_ctrl.sv
hw/rtl/mpss_dp.sv
hw/rtl/multi_policy_stride_scheduler_top.sv
hw/rtl/mpss_chk.sv
test/mpss_checker.sv
test/tb_top.sv
